@@ hdl/itp_pkg.sv @@
`timescale 1ns / 1ps

package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_OPEN  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_UNMATCHED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_FLUSH = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_OP    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_READ   = 3'd1,
    S_CHECK  = 3'd2,
    S_PUSH   = 3'd3,
    S_FINISH = 3'd4
  } state_t;

  // Port signals between the sequencer and the operator stack memory.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [2:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } stack_ctl_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  function automatic op_t classify(input logic [7:0] c);
    op_t r;
    case (c)
      CH_PLUS:  r = OP_ADD;
      CH_MINUS: r = OP_SUB;
      CH_STAR:  r = OP_MUL;
      CH_SLASH: r = OP_DIV;
      CH_OPEN:  r = OP_OPEN;
      default:  r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] op_char(input op_t op);
    logic [7:0] r;
    case (op)
      OP_ADD:  r = CH_PLUS;
      OP_SUB:  r = CH_MINUS;
      OP_MUL:  r = CH_STAR;
      OP_DIV:  r = CH_SLASH;
      OP_OPEN: r = CH_OPEN;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] op_prec(input op_t op);
    logic [1:0] r;
    case (op)
      OP_ADD, OP_SUB: r = 2'd1;
      OP_MUL, OP_DIV: r = 2'd2;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/itp_in_if.sv @@
`timescale 1ns / 1ps

interface itp_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] symbol;

  modport source (output valid, output action, output symbol, input ready);
  modport sink   (input valid, input action, input symbol, output ready);
endinterface

@@ hdl/itp_out_if.sv @@
`timescale 1ns / 1ps

interface itp_out_if;
  logic       valid;
  logic       ready;
  logic       has_symbol;
  logic [7:0] out_symbol;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, output has_symbol, output out_symbol, output status,
                  output last_of_run, input ready);
  modport sink   (input valid, input has_symbol, input out_symbol, input status,
                  input last_of_run, output ready);
endinterface

@@ hdl/infix_to_postfix_converter.sv @@
`timescale 1ns / 1ps

// Shunting-yard infix to postfix converter. Each input word carries one ASCII
// character (or an end-of-expression flush); each input word yields one or more
// output words, the final one marked by last_of_run and carrying the status.
// Digits and ignored characters go straight to the final word, and a '(' is
// pushed first. A flush or an unmatched ')' pops every stack entry, and a
// matched ')' pops entries up to its '(', the '(' included. An operator pops
// entries until it stops at an entry that stays on the stack, and is then
// pushed if the stack is not full. Each entry is read from the operator stack
// memory through its registered read port before the sequencer decides on it.
// The input is not ready while a word is being worked on, and the sequencer
// also stalls whenever a word has to move into the output register while that
// register is still full.
module infix_to_postfix_converter
  import itp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  itp_in_if.sink       in_ch,
  itp_out_if.source    out_ch
);

  state_t            state;
  state_t            state_next;
  kind_t             kind;
  op_t               code;
  status_t           status;
  logic [CNT_W-1:0]  count;
  logic              pend_valid;
  logic [7:0]        pend_sym;

  logic              ov;
  logic              o_has;
  logic [7:0]        o_sym;
  logic [1:0]        o_status;
  logic              o_last;

  stack_ctl_t        ctl;
  logic [2:0]        rd_data;
  op_t               top;

  logic              out_free;
  logic              stack_empty;
  logic              stack_full;
  logic              accept;
  logic              pop;
  logic              emit;
  logic              send_pend;
  logic              stall;
  logic              push;
  logic              finish;
  logic [CNT_W-1:0]  count_dec;

  assign top         = op_t'(rd_data);
  assign out_free    = !ov || out_ch.ready;
  assign stack_empty = (count == '0);
  assign stack_full  = (count == CNT_W'(STACK_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign count_dec   = count - CNT_W'(1);

  assign in_ch.ready = (state == S_IDLE);

  // The top entry always sits just below the fill count.
  assign ctl.rd_addr = count_dec[ADDR_W-1:0];
  assign ctl.wr_addr = count[ADDR_W-1:0];
  assign ctl.wr_data = code;
  assign ctl.wr_en   = push;
  assign ctl.rd_en   = (state == S_READ) && !stack_empty;

  itp_stack u_stack (
    .clk     (clk),
    .ctl     (ctl),
    .rd_data (rd_data)
  );

  // Control outputs of the sequencer.
  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    stall     = 1'b0;
    push      = 1'b0;
    finish    = 1'b0;
    send_pend = 1'b0;
    case (state)
      S_CHECK: begin
        case (kind)
          KIND_FLUSH, KIND_CLOSE: begin
            pop  = 1'b1;
            emit = (top != OP_OPEN);
          end
          KIND_OP: begin
            if (!(top == OP_OPEN || op_prec(top) < op_prec(code))) begin
              pop  = 1'b1;
              emit = 1'b1;
            end
          end
          default: begin
          end
        endcase
        // A symbol still held back must leave before a new one replaces it.
        if (emit && pend_valid && !out_free) begin
          pop   = 1'b0;
          emit  = 1'b0;
          stall = 1'b1;
        end
        send_pend = emit && pend_valid;
      end
      S_PUSH: begin
        push = !stack_full;
      end
      S_FINISH: begin
        finish = out_free;
      end
      default: begin
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.action) begin
            state_next = S_READ;
          end else if (in_ch.symbol >= CH_ZERO && in_ch.symbol <= CH_NINE) begin
            state_next = S_FINISH;
          end else if (in_ch.symbol == CH_CLOSE) begin
            state_next = S_READ;
          end else if (classify(in_ch.symbol) == OP_OPEN) begin
            state_next = S_PUSH;
          end else if (classify(in_ch.symbol) != OP_NONE) begin
            state_next = S_READ;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_READ: begin
        if (!stack_empty) begin
          state_next = S_CHECK;
        end else if (kind == KIND_OP) begin
          state_next = S_PUSH;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CHECK: begin
        if (stall) begin
          state_next = S_CHECK;
        end else if (!pop) begin
          state_next = S_PUSH;
        end else if (kind == KIND_CLOSE && top == OP_OPEN) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_READ;
        end
      end
      S_PUSH: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      ov         <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        count <= count_dec;
      end else if (push) begin
        count <= count + CNT_W'(1);
      end
      if (accept) begin
        pend_valid <= !in_ch.action && in_ch.symbol >= CH_ZERO && in_ch.symbol <= CH_NINE;
      end else if (emit) begin
        pend_valid <= 1'b1;
      end else if (finish) begin
        pend_valid <= 1'b0;
      end
      if (send_pend || finish) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // Word context and the held-back symbol.
  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= ST_OK;
      code     <= classify(in_ch.symbol);
      pend_sym <= in_ch.symbol;
      if (in_ch.action) begin
        kind <= KIND_FLUSH;
      end else if (in_ch.symbol == CH_CLOSE) begin
        kind <= KIND_CLOSE;
      end else begin
        kind <= KIND_OP;
      end
    end else begin
      if (emit) begin
        pend_sym <= op_char(top);
      end
      if (state == S_READ && stack_empty && kind == KIND_CLOSE) begin
        status <= ST_UNMATCHED;
      end
      if (state == S_PUSH && stack_full) begin
        status <= ST_FULL;
      end
    end
  end

  // Output register: earlier symbols go out plain, the final word carries status.
  always_ff @(posedge clk) begin
    if (send_pend) begin
      o_has    <= 1'b1;
      o_sym    <= pend_sym;
      o_status <= ST_OK;
      o_last   <= 1'b0;
    end else if (finish) begin
      o_has    <= pend_valid;
      o_sym    <= pend_valid ? pend_sym : 8'h00;
      o_status <= status;
      o_last   <= 1'b1;
    end
  end

  assign out_ch.valid       = ov;
  assign out_ch.has_symbol  = o_has;
  assign out_ch.out_symbol  = o_sym;
  assign out_ch.status      = o_status;
  assign out_ch.last_of_run = o_last;

endmodule

@@ hdl/itp_stack.sv @@
`timescale 1ns / 1ps

module itp_stack
  import itp_pkg::*;
(
  input  logic       clk,
  input  stack_ctl_t ctl,
  output logic [2:0] rd_data
);

  // Entries are only ever read below the fill count, so no reset is needed.
  logic [2:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule
